// ----- hdl/sso_pkg.sv -----
// shared types and constants for the second-order state-space block
package sso_pkg;

	// coefficient and state formats
	localparam int COEF_W    = 16;
	localparam int STATE_W   = 24;
	localparam int FRAC_BITS = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROW_ONE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_ROW_TWO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_PAIR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C_PAIR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE = 3'd5;

	// which product row the multipliers work on
	typedef enum logic [1:0] {
		ROW_N1 = 2'd0,
		ROW_N2 = 2'd1,
		ROW_Y  = 2'd2
	} row_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mul_en;
		row_t row;
		logic load_n1;
		logic load_n2;
		logic load_y;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ----- hdl/sso_datapath.sv -----
// datapath: config registers, state, three shared multipliers, round and saturate
module sso_datapath #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  logic [2:0]                cfg_idx,
	input  logic [31:0]               cfg_wdata,
	input  logic [SAMPLE_WIDTH-1:0]   sample_in,
	input  sso_pkg::cmd_t             cmd,
	output sso_pkg::status_t          status,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SAMPLE_WIDTH-1:0]   sample_out
);
	import sso_pkg::*;

	localparam int U_PROD_W = COEF_W + SAMPLE_WIDTH;
	localparam int X_PROD_W = COEF_W + STATE_W;
	localparam int PROD_W   = (U_PROD_W > X_PROD_W) ? U_PROD_W : X_PROD_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int RND_W    = SUM_W - FRAC_BITS;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [RND_W-1:0] ST_MAX = RND_W'($signed({1'b0, {(STATE_W-1){1'b1}}}));
	localparam logic signed [RND_W-1:0] ST_MIN = RND_W'($signed({1'b1, {(STATE_W-1){1'b0}}}));
	localparam logic signed [RND_W-1:0] Y_MAX =
		RND_W'($signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
	localparam logic signed [RND_W-1:0] Y_MIN =
		RND_W'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

	logic [CFG_W-1:0] a_row_one_q, a_row_two_q, b_pair_q, c_pair_q, init_state_q;
	logic [COEF_W-1:0] d_gain_q;
	logic started_q;
	logic signed [STATE_W-1:0] x1_q, x2_q, n1_q;
	logic signed [SAMPLE_WIDTH-1:0] u_q, y_q;
	logic out_valid_q;
	logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;

	logic signed [COEF_W-1:0] coef0, coef1, coef2;
	logic signed [X_PROD_W-1:0] mul0, mul1;
	logic signed [U_PROD_W-1:0] mul2;
	logic signed [SUM_W-1:0] sum;
	logic signed [RND_W-1:0] rnd;
	logic signed [STATE_W-1:0] n_sat;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_row_one_q  <= '0;
			a_row_two_q  <= '0;
			b_pair_q     <= '0;
			c_pair_q     <= '0;
			d_gain_q     <= '0;
			init_state_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_A_ROW_ONE:  a_row_one_q  <= cfg_wdata;
				REG_A_ROW_TWO:  a_row_two_q  <= cfg_wdata;
				REG_B_PAIR:     b_pair_q     <= cfg_wdata;
				REG_C_PAIR:     c_pair_q     <= cfg_wdata;
				REG_D_GAIN:     d_gain_q     <= cfg_wdata[COEF_W-1:0];
				REG_INIT_STATE: init_state_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// coefficient selection per row
	always_comb begin
		case (cmd.row)
			ROW_N1: begin
				coef0 = $signed(a_row_one_q[15:0]);
				coef1 = $signed(a_row_one_q[31:16]);
				coef2 = $signed(b_pair_q[15:0]);
			end
			ROW_N2: begin
				coef0 = $signed(a_row_two_q[15:0]);
				coef1 = $signed(a_row_two_q[31:16]);
				coef2 = $signed(b_pair_q[31:16]);
			end
			ROW_Y: begin
				coef0 = $signed(c_pair_q[15:0]);
				coef1 = $signed(c_pair_q[31:16]);
				coef2 = $signed(d_gain_q);
			end
			default: begin
				coef0 = '0;
				coef1 = '0;
				coef2 = '0;
			end
		endcase
	end

	// the y row sees the state already updated, so each multiplier always takes the same state or sample operand
	assign mul0 = coef0 * x1_q;
	assign mul1 = coef1 * x2_q;
	assign mul2 = coef2 * u_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			p0_q <= PROD_W'(mul0);
			p1_q <= PROD_W'(mul1);
			p2_q <= PROD_W'(mul2);
		end
	end

	// sum, round half up, saturate
	assign sum = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q) + ROUND_BIAS;
	assign rnd = $signed(sum[SUM_W-1:FRAC_BITS]);

	always_comb begin
		if (rnd > ST_MAX)
			n_sat = ST_MAX[STATE_W-1:0];
		else if (rnd < ST_MIN)
			n_sat = ST_MIN[STATE_W-1:0];
		else
			n_sat = rnd[STATE_W-1:0];
		if (rnd > Y_MAX)
			y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
		else if (rnd < Y_MIN)
			y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
		else
			y_sat = rnd[SAMPLE_WIDTH-1:0];
	end

	// state vector and first-item load from the initial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			x1_q      <= '0;
			x2_q      <= '0;
		end else begin
			if (cmd.capture && !started_q) begin
				started_q <= 1'b1;
				x1_q      <= STATE_W'($signed(init_state_q[15:0]));
				x2_q      <= STATE_W'($signed(init_state_q[31:16]));
			end
			if (cmd.load_n2) begin
				x1_q <= n1_q;
				x2_q <= n_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			u_q <= $signed(sample_in);
		if (cmd.load_n1)
			n1_q <= n_sat;
		if (cmd.load_y)
			y_q <= y_sat;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_y)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = y_q;

endmodule

// ----- hdl/sso_ctrl.sv -----
// controller: sequences the three product rows and the output load
module sso_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sso_pkg::status_t  status,
	output sso_pkg::cmd_t     cmd
);
	import sso_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL_N1 = 6'b000010,
		ST_MUL_N2 = 6'b000100,
		ST_UPD    = 6'b001000,
		ST_MUL_Y  = 6'b010000,
		ST_OUT    = 6'b100000
	} fsm_t;

	fsm_t state_q, state_d;
	logic capture;

	// a new item may enter while the last result is handed over
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_OUT && status.out_free);
	assign capture  = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.row     = ROW_N1;
		cmd.capture = capture;
		case (state_q)
			ST_IDLE: begin
				if (capture)
					state_d = ST_MUL_N1;
			end
			ST_MUL_N1: begin
				cmd.mul_en = 1'b1;
				cmd.row    = ROW_N1;
				state_d    = ST_MUL_N2;
			end
			ST_MUL_N2: begin
				cmd.load_n1 = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.row     = ROW_N2;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				cmd.load_n2 = 1'b1;
				state_d     = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_en = 1'b1;
				cmd.row    = ROW_Y;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_y = 1'b1;
					state_d    = capture ? ST_MUL_N1 : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hdl/state_space_second_order.sv -----
// Second-order state-space system: x = A*x + B*u, y = C*x + D*u, saturated.
// Each item steps through MUL_N1, MUL_N2, UPD, MUL_Y and OUT; a new item is
// taken only in OUT or IDLE, as three dependent product rows share
// one bank of three multipliers, each followed by a sum and saturate step.
// Reset clears the config registers, the state and the result valid; the first
// item loads init_state.
module state_space_second_order #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [31:0]                         cfg_data,
	// input items
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
	// result items
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata   // sample_out
);
	import sso_pkg::*;

	localparam int TD_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	cmd_t    cmd;
	status_t status;
	logic [SAMPLE_WIDTH-1:0] sample_out;

	assign cfg_ready = 1'b1;

	sso_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sso_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.sample_in  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.sample_out (sample_out)
	);

	// zero-pad result to whole bytes
	assign m_axis_tdata = TD_W'(sample_out);

endmodule
